### design/multi_stack_shared_pool_core_assert.svh
// Assertion macros for the multi-stack shared-pool core checker.
// Needs a clk_i clock and an rst_ni active-low reset in the scope of each use.
`ifndef MULTI_STACK_SHARED_POOL_CORE_ASSERT_SVH
`define MULTI_STACK_SHARED_POOL_CORE_ASSERT_SVH

// Whenever the condition holds at a clock edge, the consequence holds at that edge.
`define MSSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("multi-stack core assertion failed");

// The condition holds at every clock edge outside reset.
`define MSSP_ASSERT_ALWAYS(label, cond) \
  `MSSP_ASSERT_IMPL(label, 1'b1, cond)

`endif

### design/mssp_pkg.sv
// Shared types and constants for the multi-stack shared-pool core.
// Used by the front end, the job queue, the back end, the top level and the checker.
package mssp_pkg;

  localparam int ID_W        = 6;
  localparam int WORD_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  // Command codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_e;

  // Status codes of a result.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_POOL_FULL = 3'd2,
    ST_NO_STACKS = 3'd3,
    ST_BAD_ID    = 3'd4
  } status_e;

  // Operations handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_REPORT = 3'd0,
    OP_CREATE = 3'd1,
    OP_PUSH   = 3'd2,
    OP_POP    = 3'd3,
    OP_PEEK   = 3'd4
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_TOP  = 2'd1,
    BK_NODE = 2'd2
  } back_state_e;

  typedef struct packed {
    cmd_e                     command;
    logic [ID_W-1:0]          stack_sel;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WORD_W-1:0] data;
    logic [ID_W-1:0]          new_stack;
  } result_t;

  // One classified command waiting in the queue.
  typedef struct packed {
    op_e                      op;
    status_e                  status;
    logic [ID_W-1:0]          stack_sel;
    logic [ID_W-1:0]          new_stack;
    logic signed [WORD_W-1:0] value;
  } job_t;

endpackage

### design/mssp_front.sv
// Front end of the multi-stack core: accepts commands, checks ids and stack count.
// Depends on mssp_pkg; feeds classified jobs into mssp_queue.
module mssp_front #(
  parameter int NUM_STACKS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  mssp_pkg::cmd_t  cmd_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output mssp_pkg::job_t  q_job_o,
  output logic            busy
);
  import mssp_pkg::*;

  localparam int SO_W      = $clog2(NUM_STACKS + 1);
  localparam int TOP_DEPTH = (NUM_STACKS < (1 << ID_W)) ? NUM_STACKS : (1 << ID_W);
  localparam int CMP_W     = (SO_W > ID_W + 1) ? SO_W : ID_W + 1;

  logic [SO_W-1:0] stacks_open_q, stacks_open_d;
  logic            accept;
  job_t            job;

  // A transfer happens whenever start is high and the queue has room.
  assign accept   = start & ~q_full_i;
  assign busy     = q_full_i;
  assign q_push_o = accept;
  assign q_job_o  = job;

  // Classify the command and count the stacks that have been opened.
  always_comb begin
    job           = '0;
    job.op        = OP_REPORT;
    job.status    = ST_OK;
    job.stack_sel = cmd_i.stack_sel;
    job.value     = cmd_i.value;
    stacks_open_d = stacks_open_q;
    unique case (cmd_i.command)
      CMD_CREATE: begin
        if (stacks_open_q == SO_W'(NUM_STACKS)) begin
          job.status = ST_NO_STACKS;
        end else begin
          job.new_stack = ID_W'(stacks_open_q);
          // Ids past the addressable range get no top pointer.
          if (CMP_W'(stacks_open_q) < CMP_W'(TOP_DEPTH)) begin
            job.op = OP_CREATE;
          end
          if (accept) begin
            stacks_open_d = stacks_open_q + 1'b1;
          end
        end
      end
      CMD_PUSH, CMD_POP, CMD_PEEK: begin
        if (CMP_W'(cmd_i.stack_sel) >= CMP_W'(stacks_open_q)) begin
          job.status = ST_BAD_ID;
        end else begin
          unique case (cmd_i.command)
            CMD_PUSH: job.op = OP_PUSH;
            CMD_POP:  job.op = OP_POP;
            default:  job.op = OP_PEEK;
          endcase
        end
      end
      default: job.status = ST_BAD_ID;
    endcase
  end

  // Stack counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stacks_open_q <= '0;
    end else begin
      stacks_open_q <= stacks_open_d;
    end
  end

endmodule

### design/mssp_queue.sv
// Short job queue between the front end and the back end of the multi-stack core.
// Depends on mssp_pkg for the job type and the queue depth.
module mssp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mssp_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mssp_pkg::job_t  job_o
);
  import mssp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = slots_q[rd_ptr_q];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### design/mssp_back.sv
// Back end of the multi-stack core: top-pointer memory, node pool and free list.
// Depends on mssp_pkg; takes jobs from mssp_queue and drives the result register.
module mssp_back #(
  parameter int NUM_STACKS = 64,
  parameter int POOL_NODES = 1024,
  parameter int DATA_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  mssp_pkg::job_t    q_job_i,
  output logic              q_pop_o,
  output logic              done_o,
  output mssp_pkg::result_t result_o
);
  import mssp_pkg::*;

  localparam int TOP_DEPTH = (NUM_STACKS < (1 << ID_W)) ? NUM_STACKS : (1 << ID_W);
  localparam int TOP_AW    = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
  localparam int NODE_AW   = $clog2(POOL_NODES);
  localparam int LINK_W    = $clog2(POOL_NODES + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);

  // Memories: top pointer per stack, value and link per pool node.
  logic [LINK_W-1:0]    top_mem   [TOP_DEPTH];
  logic [DATA_BITS-1:0] value_mem [POOL_NODES];
  logic [LINK_W-1:0]    link_mem  [POOL_NODES];

  logic [LINK_W-1:0]    top_rd_q;
  logic [DATA_BITS-1:0] value_rd_q;
  logic [LINK_W-1:0]    link_rd_q;

  back_state_e          state_q, state_d;
  job_t                 job_q, job_d;
  logic [LINK_W-1:0]    free_head_q, free_head_d;
  logic [LINK_W-1:0]    fresh_q, fresh_d;
  logic [NODE_AW-1:0]   node_q, node_d;
  logic                 done_q, done_d;
  result_t              result_q, result_d;

  logic                 top_we;
  logic [TOP_AW-1:0]    top_waddr, top_raddr;
  logic [LINK_W-1:0]    top_wdata;
  logic                 value_we, link_we;
  logic [NODE_AW-1:0]   node_waddr, node_raddr;
  logic [DATA_BITS-1:0] value_wdata;
  logic [LINK_W-1:0]    link_wdata;

  assign done_o   = done_q;
  assign result_o = result_q;

  // Sequencer: the top pointer is read first, then the node it points to.
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    node_d      = node_q;
    done_d      = 1'b0;
    result_d    = '0;
    q_pop_o     = 1'b0;
    top_we      = 1'b0;
    top_waddr   = job_q.stack_sel[TOP_AW-1:0];
    top_wdata   = NULL_LINK;
    top_raddr   = q_job_i.stack_sel[TOP_AW-1:0];
    value_we    = 1'b0;
    link_we     = 1'b0;
    node_waddr  = node_q;
    node_raddr  = free_head_q[NODE_AW-1:0];
    value_wdata = DATA_BITS'($signed(job_q.value));
    link_wdata  = top_rd_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          unique case (q_job_i.op)
            OP_CREATE: begin
              // A new stack starts empty.
              top_we             = 1'b1;
              top_waddr          = q_job_i.new_stack[TOP_AW-1:0];
              top_wdata          = NULL_LINK;
              done_d             = 1'b1;
              result_d.status    = ST_OK;
              result_d.new_stack = q_job_i.new_stack;
            end
            OP_PUSH, OP_POP, OP_PEEK: begin
              state_d = BK_TOP;
            end
            default: begin
              done_d             = 1'b1;
              result_d.status    = q_job_i.status;
              result_d.new_stack = q_job_i.new_stack;
            end
          endcase
        end
      end
      BK_TOP: begin
        state_d = BK_IDLE;
        if (job_q.op == OP_PUSH) begin
          done_d = 1'b1;
          // Freed nodes are reused before fresh ones.
          if (free_head_q < NULL_LINK) begin
            node_waddr  = free_head_q[NODE_AW-1:0];
            free_head_d = link_rd_q;
            value_we    = 1'b1;
            link_we     = 1'b1;
            top_we      = 1'b1;
            top_wdata   = free_head_q;
            result_d.status = ST_OK;
          end else if (fresh_q < NULL_LINK) begin
            node_waddr  = fresh_q[NODE_AW-1:0];
            fresh_d     = fresh_q + 1'b1;
            value_we    = 1'b1;
            link_we     = 1'b1;
            top_we      = 1'b1;
            top_wdata   = fresh_q;
            result_d.status = ST_OK;
          end else begin
            result_d.status = ST_POOL_FULL;
          end
        end else if (top_rd_q >= NULL_LINK) begin
          done_d          = 1'b1;
          result_d.status = ST_EMPTY;
        end else begin
          node_raddr = top_rd_q[NODE_AW-1:0];
          node_d     = top_rd_q[NODE_AW-1:0];
          state_d    = BK_NODE;
        end
      end
      BK_NODE: begin
        state_d         = BK_IDLE;
        done_d          = 1'b1;
        result_d.status = ST_OK;
        result_d.data   = WORD_W'(value_rd_q);
        // A pop unlinks the node and puts it on the free list.
        if (job_q.op == OP_POP) begin
          top_we      = 1'b1;
          top_wdata   = link_rd_q;
          link_we     = 1'b1;
          node_waddr  = node_q;
          link_wdata  = free_head_q;
          free_head_d = LINK_W'(node_q);
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      free_head_q <= NULL_LINK;
      fresh_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      done_q      <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    node_q   <= node_d;
    result_q <= result_d;
  end

  // Top-pointer memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (top_we) begin
      top_mem[top_waddr] <= top_wdata;
    end
    top_rd_q <= top_mem[top_raddr];
  end

  // Node value memory.
  always_ff @(posedge clk_i) begin
    if (value_we) begin
      value_mem[node_waddr] <= value_wdata;
    end
    value_rd_q <= value_mem[node_raddr];
  end

  // Node link memory.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[node_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[node_raddr];
  end

endmodule

### design/multi_stack_shared_pool_core.sv
// Multi-stack core: many LIFO stacks kept as linked nodes in one shared pool.
// Usage:
//   A command (create, push, pop or peek) is transferred at a rising edge where
//   start is high and busy is low. busy rises only when the two-entry command
//   queue is full. Every command gives exactly one result on result_o, shown for
//   one cycle with done_o high; results come out in command order.
// Order of work: create and any rejected command are answered from the back end's
//   idle state; a push reads the top pointer first, and a pop or peek reads the
//   top pointer, then the node memory unless the stack is empty. The back end
//   finishes one command before it takes the next from the queue. The front end
//   keeps taking commands while the back end works, until the queue fills.
// Reset clears the stack count, the free list, the fresh-node count, the queue
//   and the sequencer; stacks get their empty top pointer when they are created.
// The receiver cannot stall: a result is transferred in the cycle it is shown.
module multi_stack_shared_pool_core #(
  parameter int NUM_STACKS = 64,
  parameter int POOL_NODES = 1024,
  parameter int DATA_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  mssp_pkg::cmd_t    cmd_i,
  output logic              busy,
  output logic              done_o,
  output mssp_pkg::result_t result_o
);
  import mssp_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t front_job, back_job;

  mssp_front #(
    .NUM_STACKS(NUM_STACKS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (front_job),
    .busy     (busy)
  );

  mssp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (back_job)
  );

  mssp_back #(
    .NUM_STACKS(NUM_STACKS),
    .POOL_NODES(POOL_NODES),
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (back_job),
    .q_pop_o   (q_pop),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule

### design/mssp_checker.sv
// Port-level checker for the multi-stack core, bound to the top level.
// Depends on mssp_pkg and the macros in multi_stack_shared_pool_core_assert.svh.
`include "multi_stack_shared_pool_core_assert.svh"

module mssp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input mssp_pkg::result_t result_o
);
  import mssp_pkg::*;

  localparam int MAX_PENDING = QUEUE_DEPTH + 1;
  localparam int PEND_W      = $clog2(MAX_PENDING + 2);

  logic [PEND_W-1:0] pending_q;
  logic              fail_shown;
  logic              payload_clear;

  // Commands transferred in but whose result has not yet been transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + PEND_W'(start & ~busy) - PEND_W'(done_o);
    end
  end

  // A shown result that failed, and whether its payload fields are all zero.
  assign fail_shown    = done_o && (result_o.status != ST_OK);
  assign payload_clear = (result_o.data == '0) && (result_o.new_stack == '0);

  // A failed command carries neither data nor a new stack id.
  `MSSP_ASSERT_IMPL(a_fail_no_payload, fail_shown, payload_clear)

  // Every result answers a command that is still pending.
  `MSSP_ASSERT_IMPL(a_result_has_command, done_o, pending_q != '0)

  // busy only rises once the queue holds a full backlog.
  `MSSP_ASSERT_IMPL(a_busy_means_backlog, busy, pending_q >= PEND_W'(QUEUE_DEPTH))

  // No more commands are in flight than the queue and the back end can hold.
  `MSSP_ASSERT_ALWAYS(a_backlog_bounded, pending_q <= PEND_W'(MAX_PENDING))

endmodule

bind multi_stack_shared_pool_core mssp_checker u_checker (.*);

### sim/multi_stack_shared_pool_core_test.sv
// Self-checking testbench for multi_stack_shared_pool_core.
// Needs mssp_pkg and the core; directed table first, then random command streams
// checked against an in-bench model of the stacks, the node pool and the free list.
`timescale 1ns / 100ps

module multi_stack_shared_pool_core_test;
  import mssp_pkg::*;

  localparam int NUM_STACKS = 64;
  localparam int POOL_NODES = 1024;
  localparam logic [10:0] NULL_NODE = 11'(POOL_NODES);
  localparam int CYCLE_LIMIT = 400000;

  // One line of the directed table; want is used only when typed is set.
  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t want;
  } step_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  cmd_t    cmd_i = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  // Model of the stacks: top pointers, node words and links, free list.
  logic [10:0] stack_top [NUM_STACKS];
  logic [31:0] node_word [POOL_NODES];
  logic [10:0] node_next [POOL_NODES];
  logic [10:0] free_top = NULL_NODE;
  logic [10:0] fresh_used = '0;
  logic [6:0]  stacks_made = '0;

  result_t     pending_results [$];
  result_t     oldest;
  int          status_tally [5];
  int          errors = 0;
  int          cmds_sent = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          focus_id = 0;
  step_row_t   plan [$];

  multi_stack_shared_pool_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Apply one command to the model and return the result it should give.
  function automatic result_t predict_result(input cmd_t c);
    result_t     r;
    logic [10:0] nd;
    r.status    = ST_OK;
    r.data      = '0;
    r.new_stack = '0;
    if (c.command == CMD_CREATE) begin
      if (stacks_made >= NUM_STACKS) begin
        r.status = ST_NO_STACKS;
      end else begin
        r.new_stack = stacks_made[5:0];
        stack_top[stacks_made[5:0]] = NULL_NODE;
        stacks_made++;
      end
    end else if (c.stack_sel >= stacks_made) begin
      r.status = ST_BAD_ID;
    end else if (c.command == CMD_PUSH) begin
      // A freed node is reused before a never-used one is taken.
      nd = NULL_NODE;
      if (free_top != NULL_NODE) begin
        nd = free_top;
        free_top = node_next[nd];
      end else if (fresh_used < POOL_NODES) begin
        nd = fresh_used;
        fresh_used++;
      end else begin
        r.status = ST_POOL_FULL;
      end
      if (nd != NULL_NODE) begin
        node_word[nd] = c.value;
        node_next[nd] = stack_top[c.stack_sel];
        stack_top[c.stack_sel] = nd;
      end
    end else begin
      nd = stack_top[c.stack_sel];
      if (nd == NULL_NODE) begin
        r.status = ST_EMPTY;
      end else begin
        r.data = node_word[nd];
        if (c.command == CMD_POP) begin
          stack_top[c.stack_sel] = node_next[nd];
          node_next[nd] = free_top;
          free_top = nd;
        end
      end
    end
    status_tally[r.status]++;
    return r;
  endfunction

  function automatic step_row_t step_row(input cmd_e op, input int id, input logic [31:0] val,
                                         input bit typed, input status_e st,
                                         input logic [31:0] dat, input int nid);
    step_row_t s;
    s.c.command      = op;
    s.c.stack_sel    = 6'(id);
    s.c.value        = val;
    s.typed          = typed;
    s.want.status    = st;
    s.want.data      = dat;
    s.want.new_stack = 6'(nid);
    return s;
  endfunction

  // Sender gaps: mostly none or short, a few long, and now and then a burst with none.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r == 0) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly existing stacks, often one favored stack so that some grow deep.
  function automatic logic [5:0] pick_stack();
    if (stacks_made == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    if ($urandom_range(0, 1) == 1) return 6'(focus_id % stacks_made);
    return 6'($urandom_range(0, stacks_made - 1));
  endfunction

  // Hold a command until it is transferred, then queue its expected result.
  // Called and returns at a rising edge.
  task automatic issue(input cmd_t c, input bit typed, input result_t want);
    bit      taken;
    result_t model_res;
    int      gap;
    start <= 1'b1;
    cmd_i <= c;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    model_res = predict_result(c);
    pending_results.push_back(typed ? want : model_res);
    cmds_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_item(input int create_w, input int push_w, input int pop_w);
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    c.value = $urandom();
    if (r < create_w) c.command = CMD_CREATE;
    else if (r < create_w + push_w) c.command = CMD_PUSH;
    else if (r < create_w + push_w + pop_w) c.command = CMD_POP;
    else c.command = CMD_PEEK;
    c.stack_sel = pick_stack();
    if ($urandom_range(0, 19) == 0) focus_id = $urandom_range(0, 63);
    issue(c, 1'b0, '0);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  // Check each result against the oldest expectation.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d data %h id %0d", $time,
                 result_o.status, result_o.data, result_o.new_stack);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (result_o.status !== oldest.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time,
                   oldest.status, result_o.status);
          errors++;
        end
        if (result_o.data !== oldest.data) begin
          $display("%0t: data mismatch: expected %h actual %h", $time,
                   oldest.data, result_o.data);
          errors++;
        end
        if (result_o.new_stack !== oldest.new_stack) begin
          $display("%0t: new_stack mismatch: expected %0d actual %0d", $time,
                   oldest.new_stack, result_o.new_stack);
          errors++;
        end
      end
    end
  end

  initial begin
    int directed;
    int n;
    // Directed table: rejects before any stack exists, empty stacks, extreme words,
    // node reuse through the free list and an id one past the last stack.
    plan = '{
      step_row(CMD_PUSH,   0, 32'h0000_0005, 1, ST_BAD_ID, 32'h0, 0),
      step_row(CMD_POP,    0, 32'h0000_0000, 1, ST_BAD_ID, 32'h0, 0),
      step_row(CMD_PEEK,  63, 32'hFFFF_FFFF, 1, ST_BAD_ID, 32'h0, 0),
      step_row(CMD_CREATE, 0, 32'h0000_0000, 1, ST_OK,     32'h0, 0),
      step_row(CMD_POP,    0, 32'h0000_0000, 1, ST_EMPTY,  32'h0, 0),
      step_row(CMD_PEEK,   0, 32'h0000_0000, 1, ST_EMPTY,  32'h0, 0),
      step_row(CMD_PUSH,   0, 32'h7FFF_FFFF, 1, ST_OK,     32'h0, 0),
      step_row(CMD_PUSH,   0, 32'h8000_0000, 1, ST_OK,     32'h0, 0),
      step_row(CMD_PEEK,   0, 32'h0000_0000, 1, ST_OK,     32'h8000_0000, 0),
      step_row(CMD_POP,    0, 32'h0000_0000, 1, ST_OK,     32'h8000_0000, 0),
      step_row(CMD_POP,    0, 32'h0000_0000, 1, ST_OK,     32'h7FFF_FFFF, 0),
      step_row(CMD_POP,    0, 32'h0000_0000, 1, ST_EMPTY,  32'h0, 0),
      step_row(CMD_CREATE, 0, 32'hFFFF_FFFF, 1, ST_OK,     32'h0, 1),
      step_row(CMD_PUSH,   1, 32'hFFFF_FFFF, 1, ST_OK,     32'h0, 0),
      step_row(CMD_PUSH,   1, 32'h0000_0000, 1, ST_OK,     32'h0, 0),
      step_row(CMD_PUSH,   0, 32'h1234_5678, 1, ST_OK,     32'h0, 0),
      step_row(CMD_PEEK,   1, 32'hFFFF_FFFF, 0, ST_OK,     32'h0, 0),
      step_row(CMD_POP,    1, 32'h0000_0000, 0, ST_OK,     32'h0, 0),
      step_row(CMD_PEEK,   1, 32'h0000_0000, 0, ST_OK,     32'h0, 0),
      step_row(CMD_PEEK,   0, 32'h0000_0000, 0, ST_OK,     32'h0, 0),
      step_row(CMD_PUSH,   2, 32'hDEAD_BEEF, 1, ST_BAD_ID, 32'h0, 0),
      step_row(CMD_PUSH,  63, 32'h5A5A_5A5A, 1, ST_BAD_ID, 32'h0, 0),
      step_row(CMD_CREATE, 9, 32'h0000_0000, 1, ST_OK,     32'h0, 2),
      step_row(CMD_POP,    2, 32'h0000_0000, 1, ST_EMPTY,  32'h0, 0)
    };
    foreach (status_tally[i]) status_tally[i] = 0;

    // Reset once, then release at a clock edge.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) issue(plan[i].c, plan[i].typed, plan[i].want);
    directed = cmds_sent;
    drain();

    // Open all stacks and run past the stack limit with a mixed load.
    n = 0;
    while (n < 250) begin
      if (stacks_made < NUM_STACKS) random_item(35, 35, 18);
      else random_item(5, 45, 30);
      n++;
    end
    drain();

    // Fill the pool until pushes are refused two dozen times.
    n = 0;
    while (status_tally[ST_POOL_FULL] < 24 && n < 1600) begin
      random_item(0, 90, 4);
      n++;
    end
    drain();

    // Unwind: mostly pops, which feed the free list that later pushes take from.
    for (n = 0; n < 300; n++) random_item(5, 15, 60);
    drain();

    repeat (12) @(posedge clk_i);
    $display("Sent %0d commands (%0d directed), %0d results compared, %0d errors.",
             cmds_sent, directed, results_seen, errors);
    $display("Statuses: ok %0d, empty %0d, pool full %0d, no stacks %0d, bad id %0d.",
             status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_POOL_FULL],
             status_tally[ST_NO_STACKS], status_tally[ST_BAD_ID]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
